@@ rtl/iqd_pkg.sv @@
// shared types and constants for the int4 group dequant dot product block
// no dependencies; imported by every module under rtl
package iqd_pkg;

	// lane and field geometry
	localparam int LANES    = 8;
	localparam int LANE_W   = $clog2(LANES);
	localparam int NIB_W    = 4;
	localparam int BYTE_W   = 8;
	localparam int WORD_W   = 32;
	localparam int BYTES    = WORD_W / BYTE_W;
	localparam int ACT_W    = 16;
	localparam int SCL_W    = 16;
	localparam int Q_W      = NIB_W + 1;
	localparam int NIB_BIAS = 8;

	// arithmetic widths: dequantized weight, lane product, accumulator
	localparam int DEQ_W  = Q_W + SCL_W;
	localparam int PROD_W = ACT_W + DEQ_W;
	localparam int ACC_W  = 48;
	localparam int SUM_W  = ACC_W + 1;

	// queue geometry, both sides use two entries
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// input transaction as seen on the ports
	typedef struct packed {
		logic        [WORD_W-1:0] weight_word;
		logic signed [ACT_W-1:0]  act_0;
		logic signed [ACT_W-1:0]  act_1;
		logic signed [ACT_W-1:0]  act_2;
		logic signed [ACT_W-1:0]  act_3;
		logic signed [ACT_W-1:0]  act_4;
		logic signed [ACT_W-1:0]  act_5;
		logic signed [ACT_W-1:0]  act_6;
		logic signed [ACT_W-1:0]  act_7;
		logic signed [SCL_W-1:0]  group_scale;
		logic signed [SCL_W-1:0]  group_offset;
		logic                     last_item;
	} in_item_t;

	// result transaction as seen on the ports
	typedef struct packed {
		logic signed [ACC_W-1:0] dot_value;
		logic                    saturated;
	} out_item_t;

	// item after the front has split it into lanes
	typedef struct packed {
		logic [LANES-1:0][NIB_W-1:0] nib;
		logic [LANES-1:0][ACT_W-1:0] act;
		logic signed [SCL_W-1:0]     scale;
		logic signed [SCL_W-1:0]     offs;
		logic                        last;
	} job_t;

	// fill level of the result queue, fed back to the sequencer
	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
	} oq_stat_t;

	// lane sequencer states
	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} bk_state_t;

endpackage

@@ rtl/iqd_front.sv @@
// front part: accepts input transactions, splits them into lanes and
// holds them in a two-entry job queue; depends on iqd_pkg
module iqd_front import iqd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	output logic     job_valid,
	output job_t     job,
	input  logic     job_take
);

	job_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	job_t              job_c;
	logic              do_push;
	logic              do_pop;

	// lane l takes byte l mod 4, low nibble for lanes 0..3, high for 4..7
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			job_c.nib[l] = item.weight_word[(l % BYTES) * BYTE_W + (l / BYTES) * NIB_W +: NIB_W];
		end
		job_c.act[0] = item.act_0;
		job_c.act[1] = item.act_1;
		job_c.act[2] = item.act_2;
		job_c.act[3] = item.act_3;
		job_c.act[4] = item.act_4;
		job_c.act[5] = item.act_5;
		job_c.act[6] = item.act_6;
		job_c.act[7] = item.act_7;
		job_c.scale  = item.group_scale;
		job_c.offs   = item.group_offset;
		job_c.last   = item.last_item;
	end

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign job_valid = (cnt_q != '0);
	assign job       = ent_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = job_take && job_valid;

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= job_c;
		end
	end

endmodule

@@ rtl/iqd_back.sv @@
// back part: walks the eight lanes of each job, dequantizes, multiplies
// and accumulates with saturation; depends on iqd_pkg
module iqd_back import iqd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	input  job_t      job,
	output logic      job_take,
	input  oq_stat_t  oq_stat,
	output logic      res_push,
	output out_item_t res
);

	bk_state_t         state_q;
	bk_state_t         state_d;
	logic [LANE_W-1:0] lane_q;
	job_t              cur_q;
	logic [QCNT_W-1:0] inflight_q;

	logic              last_lane;
	logic              emit_now;
	logic              room_ok;
	logic              issue;
	logic [QCNT_W:0]   need;

	logic signed [Q_W-1:0]    q_c;
	logic signed [DEQ_W-1:0]  deq_c;
	logic signed [ACT_W-1:0]  act_c;

	logic                     v_s1;
	logic                     emit_s1;
	logic signed [DEQ_W-1:0]  deq_s1;
	logic signed [ACT_W-1:0]  act_s1;

	logic                     v_s2;
	logic                     emit_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [ACC_W-1:0]  acc_q;
	logic                     ovf_q;
	logic signed [SUM_W-1:0]  sum_c;
	logic signed [ACC_W-1:0]  sat_c;
	logic                     clamp_c;

	// admission: a job starts only if its possible result has a free slot
	assign last_lane = (lane_q == LANE_W'(LANES - 1));
	assign emit_now  = (state_q == BK_RUN) && last_lane && cur_q.last;
	assign need      = (QCNT_W + 1)'(oq_stat.count) + (QCNT_W + 1)'(inflight_q)
		+ (QCNT_W + 1)'(emit_now);
	assign room_ok   = (need < (QCNT_W + 1)'(QDEPTH));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid && room_ok) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (last_lane && !(job_valid && room_ok)) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		job_take = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				job_take = job_valid && room_ok;
			end
			BK_RUN: begin
				issue    = 1'b1;
				job_take = last_lane && job_valid && room_ok;
			end
			default: begin
				job_take = 1'b0;
				issue    = 1'b0;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			lane_q     <= '0;
			inflight_q <= '0;
		end else begin
			state_q <= state_d;
			if (job_take) begin
				lane_q <= '0;
			end else if (issue) begin
				lane_q <= lane_q + LANE_W'(1);
			end
			inflight_q <= inflight_q + QCNT_W'(emit_now) - QCNT_W'(res_push);
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			cur_q <= job;
		end
	end

	// stage 1: dequantize the selected lane, (nibble - 8) * scale + offset
	always_comb begin
		q_c   = $signed({1'b0, cur_q.nib[lane_q]}) - Q_W'(NIB_BIAS);
		deq_c = DEQ_W'(q_c) * DEQ_W'(cur_q.scale) + DEQ_W'(cur_q.offs);
		act_c = $signed(cur_q.act[lane_q]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			v_s2    <= 1'b0;
			emit_s2 <= 1'b0;
		end else begin
			v_s1    <= issue;
			emit_s1 <= emit_now;
			v_s2    <= v_s1;
			emit_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		deq_s1 <= deq_c;
		act_s1 <= act_c;
	end

	// stage 2: lane product
	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(act_s1) * PROD_W'(deq_s1);
	end

	// accumulate with clamp to the 48-bit signed range
	always_comb begin
		sum_c   = SUM_W'(acc_q) + SUM_W'(prod_s2);
		clamp_c = (sum_c[SUM_W-1] != sum_c[ACC_W-1]);
		if (!clamp_c) begin
			sat_c = sum_c[ACC_W-1:0];
		end else if (sum_c[SUM_W-1]) begin
			sat_c = {1'b1, {(ACC_W - 1){1'b0}}};
		end else begin
			sat_c = {1'b0, {(ACC_W - 1){1'b1}}};
		end
	end

	assign res_push      = v_s2 && emit_s2;
	assign res.dot_value = sat_c;
	assign res.saturated = ovf_q || clamp_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (v_s2) begin
			if (emit_s2) begin
				acc_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				acc_q <= sat_c;
				ovf_q <= ovf_q || clamp_c;
			end
		end
	end

endmodule

@@ rtl/iqd_outq.sv @@
// two-entry result queue between the accumulator and the result ports
// depends on iqd_pkg
module iqd_outq import iqd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      res_push,
	input  out_item_t res,
	output oq_stat_t  oq_stat,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	out_item_t         ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign empty         = (cnt_q == '0);
	assign result        = ent_q[rd_q];
	assign do_pop        = pop && !empty;
	assign oq_stat.count = cnt_q;
	assign oq_stat.full  = (cnt_q == QCNT_W'(QDEPTH));

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (res_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(res_push) - QCNT_W'(do_pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (res_push) begin
			ent_q[wr_q] <= res;
		end
	end

endmodule

@@ rtl/int4_group_dequant_dot_product.sv @@
// top level of the int4 group dequant dot product block
// depends on iqd_pkg, iqd_front, iqd_back, iqd_outq
//
//   channel   handshake          payload     accepted when
//   input     push / full        item        push && !full
//   result    empty / pop        result      pop && !empty
//
// the lane sequencer walks the eight lanes of each item, one lane per cycle,
// through a dequant stage, a multiply stage and the saturating accumulator
// reset clears queues, sequencer and accumulator; no clearing pass
// a stalled result queue holds back the sequencer only when it has no room
// for a result; up to two items wait in the front queue meanwhile
module int4_group_dequant_dot_product import iqd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic      job_valid;
	job_t      job;
	logic      job_take;
	oq_stat_t  oq_stat;
	logic      res_push;
	out_item_t res;

	// accept and split items
	iqd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take)
	);

	// lane sequencer and accumulator
	iqd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.oq_stat   (oq_stat),
		.res_push  (res_push),
		.res       (res)
	);

	// result queue
	iqd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.oq_stat  (oq_stat),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	// the admission credit must keep the result queue from overflowing
	a_no_oq_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !oq_stat.full)
		else $error("result written into a full result queue");

	// a result shows up only after the accumulator writes one
	a_empty_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !res_push) |=> empty)
		else $error("result queue left empty without a write");

	// the front queue drains only through the sequencer
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !job_take) |=> full)
		else $error("input queue left full without a job taken");

endmodule

@@ verif/tb_int4_group_dequant_dot_product.sv @@
// self-checking testbench for int4_group_dequant_dot_product
// predicts each dot product from accepted items and checks results in order
// depends on iqd_pkg and the int4_group_dequant_dot_product rtl
module tb_int4_group_dequant_dot_product;
	import iqd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam int     RANDOM_ITEMS = 690;
	localparam int     LONG_RUN = 400;
	localparam int     CORNER_ITEMS = 8;
	localparam int     CLK_HALF = 10;
	localparam int     RESET_CYCLES = 11;
	localparam int     DRAIN_CYCLES = 40;
	localparam longint LIMIT_NS = 64'd10_000_000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  item = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t result;

	// items waiting to be driven, dot products waiting to come out
	in_item_t  queued_items[$];
	out_item_t expected_dots[$];

	// predicted accumulator state
	longint    acc_sum = 0;
	logic      acc_clamped = 1'b0;

	int        in_gap = 0;
	int        out_gap = 0;
	int        mismatch_count = 0;
	int        accepted_count = 0;
	int        total_items = 0;
	logic      in_fired = 1'b0;
	out_item_t dot_want;
	in_item_t  gen_item;

	int4_group_dequant_dot_product u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// clock
	always begin
		#(CLK_HALF) clk = ~clk;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return int'($urandom_range(1, 3));
		end
		return int'($urandom_range(8, 40));
	endfunction

	// 16-bit value biased toward the extremes
	function automatic logic [15:0] pick16();
		int unsigned sel;
		sel = $urandom_range(0, 7);
		case (sel)
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic in_item_t rand_item(input logic last);
		in_item_t it;
		it.weight_word  = $urandom();
		it.act_0        = pick16();
		it.act_1        = pick16();
		it.act_2        = pick16();
		it.act_3        = pick16();
		it.act_4        = pick16();
		it.act_5        = pick16();
		it.act_6        = pick16();
		it.act_7        = pick16();
		it.group_scale  = pick16();
		it.group_offset = pick16();
		it.last_item    = last;
		return it;
	endfunction

	// step the predicted accumulator by one accepted transaction
	function automatic void predict(input in_item_t it);
		longint    acts [LANES];
		longint    scl;
		longint    ofs;
		longint    q;
		longint    deq;
		longint    prod;
		longint    s;
		out_item_t dot;
		acts[0] = longint'($signed(it.act_0));
		acts[1] = longint'($signed(it.act_1));
		acts[2] = longint'($signed(it.act_2));
		acts[3] = longint'($signed(it.act_3));
		acts[4] = longint'($signed(it.act_4));
		acts[5] = longint'($signed(it.act_5));
		acts[6] = longint'($signed(it.act_6));
		acts[7] = longint'($signed(it.act_7));
		scl = longint'($signed(it.group_scale));
		ofs = longint'($signed(it.group_offset));
		// lane l: byte l mod 4, high nibble for the upper four lanes
		for (int l = 0; l < LANES; l++) begin
			q    = longint'(it.weight_word[(l % BYTES) * BYTE_W + (l / BYTES) * NIB_W +: NIB_W]);
			deq  = (q - longint'(NIB_BIAS)) * scl + ofs;
			prod = acts[l] * deq;
			s    = acc_sum + prod;
			if (s > ACC_HI) begin
				s           = ACC_HI;
				acc_clamped = 1'b1;
			end else if (s < ACC_LO) begin
				s           = ACC_LO;
				acc_clamped = 1'b1;
			end
			acc_sum = s;
		end
		if (it.last_item) begin
			dot.dot_value = ACC_W'(acc_sum);
			dot.saturated = acc_clamped;
			expected_dots.push_back(dot);
			acc_sum     = 0;
			acc_clamped = 1'b0;
		end
	endfunction

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			push   <= 1'b0;
			pop    <= 1'b0;
			in_gap <= 0;
			out_gap <= 0;
		end else begin
			// input side: hold a waiting transaction until it is taken
			if (push && !in_fired) begin
				push <= 1'b1;
			end else if (in_gap != 0) begin
				push   <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (queued_items.size() != 0) begin
				item   <= queued_items.pop_front();
				push   <= 1'b1;
				in_gap <= pick_gap();
			end else begin
				push <= 1'b0;
			end
			// result side
			if (out_gap != 0) begin
				pop     <= 1'b0;
				out_gap <= out_gap - 1;
			end else begin
				pop     <= 1'b1;
				out_gap <= pick_gap();
			end
		end
	end

	// monitor: predicts on accepted inputs and checks accepted results
	always @(posedge clk) begin
		in_fired <= push && !full;
		if (arst_n && push && !full) begin
			predict(item);
			accepted_count <= accepted_count + 1;
		end
		if (arst_n && pop && !empty) begin
			if (expected_dots.size() == 0) begin
				$error("unexpected result dot_value %0d saturated %0d",
					result.dot_value, result.saturated);
				mismatch_count = mismatch_count + 1;
			end else begin
				dot_want = expected_dots.pop_front();
				if (result.dot_value !== dot_want.dot_value) begin
					$error("dot_value expected %0d actual %0d",
						dot_want.dot_value, result.dot_value);
					mismatch_count = mismatch_count + 1;
				end
				if (result.saturated !== dot_want.saturated) begin
					$error("saturated expected %0d actual %0d",
						dot_want.saturated, result.saturated);
					mismatch_count = mismatch_count + 1;
				end
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		// single-item dot products with extreme operands
		for (int i = 0; i < CORNER_ITEMS; i++) begin
			gen_item = rand_item(1'b1);
			gen_item.weight_word = (i % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
			gen_item.group_scale = (i < 4) ? 16'sh8000 : 16'sh7FFF;
			gen_item.group_offset = (i % 4 < 2) ? 16'sh7FFF : 16'sh8000;
			queued_items.push_back(gen_item);
		end
		// one long dot product of largest-magnitude products
		for (int i = 0; i < LONG_RUN; i++) begin
			gen_item = rand_item(i == LONG_RUN - 1);
			gen_item.weight_word  = 32'h0000_0000;
			gen_item.act_0        = 16'sh8000;
			gen_item.act_1        = 16'sh8000;
			gen_item.act_2        = 16'sh8000;
			gen_item.act_3        = 16'sh8000;
			gen_item.act_4        = 16'sh8000;
			gen_item.act_5        = 16'sh8000;
			gen_item.act_6        = 16'sh8000;
			gen_item.act_7        = 16'sh8000;
			gen_item.group_scale  = 16'sh8000;
			gen_item.group_offset = 16'sh7FFF;
			queued_items.push_back(gen_item);
		end
		// random dot products of random length, the final one closed
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			queued_items.push_back(rand_item((i == RANDOM_ITEMS - 1)
				|| ($urandom_range(0, 3) == 0)));
		end
		total_items = queued_items.size();

		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!(accepted_count == total_items && expected_dots.size() == 0)) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_int4_group_dequant_dot_product OK");
		end else begin
			$display("tb_int4_group_dequant_dot_product NOT OK");
		end
		$finish;
	end

	// run limit
	initial begin
		#(LIMIT_NS);
		$error("run limit reached");
		$display("tb_int4_group_dequant_dot_product NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/iqd_pkg.sv
rtl/iqd_front.sv
rtl/iqd_back.sv
rtl/iqd_outq.sv
rtl/int4_group_dequant_dot_product.sv
verif/tb_int4_group_dequant_dot_product.sv
